// ----- hdl/prk_pkg.sv -----
// shared constants, types and codes of the pagerank power iteration block
// no dependencies; every other file depends on this package
package prk_pkg;

    localparam int NODES_MAX = 1024;
    localparam int EDGES_MAX = 8192;

    localparam int NODE_W  = $clog2(NODES_MAX);
    localparam int CNT_W   = $clog2(NODES_MAX + 1);
    localparam int EDGE_AW = (EDGES_MAX > 1) ? $clog2(EDGES_MAX) : 1;
    localparam int ETOT_W  = $clog2(EDGES_MAX + 1);
    localparam int DEG_W   = ETOT_W;
    localparam int IDX_W   = (ETOT_W > CNT_W) ? ETOT_W : CNT_W;

    localparam int REQ_W      = 2;
    localparam int STAT_W     = 2;
    localparam int ITER_W     = 8;
    localparam int SCORE_W    = 32;
    localparam int ALPHA_W    = 16;
    localparam int OMA_W      = ALPHA_W + 1;
    localparam int TOL_W      = 16;
    localparam int NCFG_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int PROD_W  = OMA_W + SCORE_W;
    localparam int SHARE_W = PROD_W - ALPHA_W;
    localparam int ACC_W   = SHARE_W + ETOT_W;
    localparam int DSUM_W  = SHARE_W + CNT_W;
    localparam int ERR_W   = SCORE_W + CNT_W;
    localparam int LIM_W   = CNT_W + TOL_W;
    localparam int NV_W    = ACC_W + 1;
    localparam int DIV_W   = (DSUM_W > SCORE_W) ? DSUM_W : SCORE_W;
    localparam int DVS_W   = IDX_W;

    localparam logic [NCFG_W-1:0]  NODES_RST = NCFG_W'(1024);
    localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(9830);
    localparam logic [ITER_W-1:0]  MAXIT_RST = ITER_W'(100);
    localparam logic [TOL_W-1:0]   TOL_RST   = TOL_W'(2147);

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD   = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODES = 2'd0,
        CFG_ALPHA = 2'd1,
        CFG_MAXIT = 2'd2,
        CFG_TOL   = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        DP_NOP, DP_SWEEP, DP_LATCH, DP_CLEAR, DP_ADD_RD, DP_ADD_WR, DP_RD_RD, DP_RD_CAP,
        DP_DIV_INIT, DP_CAP_INIT, DP_DIV_TELE, DP_CAP_TELE, DP_FILL, DP_ITER_START,
        DP_DANG_RD, DP_DANG_MUL, DP_DANG_ADD, DP_DIV_DANG, DP_CAP_DANG, DP_E_RD,
        DP_E_RD2, DP_E_MUL, DP_DIV_EDGE, DP_E_SKIP, DP_E_ACC, DP_IDX_CLR, DP_UPD_RD,
        DP_UPD_WR, DP_ITER_END
    } t_dp_op;

    typedef enum logic [5:0] {
        S_RST_SWEEP, S_IDLE, S_ADD_RD, S_ADD_WR, S_RD_RD, S_RD_CAP, S_CLR, S_CLR_SWEEP,
        S_INIT_DIV, S_INIT_WAIT, S_INIT_CAP, S_TELE_DIV, S_TELE_WAIT, S_TELE_CAP, S_FILL,
        S_ITER, S_DANG_RD, S_DANG_MUL, S_DANG_ADD, S_DANG_DIV, S_DANG_WAIT, S_DANG_CAP,
        S_E_RD, S_E_RD2, S_E_MUL, S_E_DIV, S_E_WAIT, S_E_ACC, S_UPD_START, S_UPD_RD,
        S_UPD_WR, S_ITER_END, S_RESP
    } t_state;

    typedef struct packed {
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic div_busy;
        logic idx_sweep_last;
        logic idx_n_last;
        logic idx_edge_last;
        logic edges_empty;
        logic edge_ok;
        logic max_zero;
        logic err_below;
        logic iter_last;
    } t_dp_status;

endpackage

// ----- hdl/prk_ifs.sv -----
// request and response channel interfaces of the pagerank block
// depends on prk_pkg for field widths
interface prk_req_if;
    logic                          valid;
    logic                          ready;
    logic [prk_pkg::REQ_W-1:0]     req_type;
    logic [prk_pkg::NODE_W-1:0]    src_node;
    logic [prk_pkg::NODE_W-1:0]    dst_node;

    modport source (output valid, req_type, src_node, dst_node, input ready);
    modport sink   (input valid, req_type, src_node, dst_node, output ready);
endinterface

interface prk_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [prk_pkg::SCORE_W-1:0]   score;
    logic [prk_pkg::ITER_W-1:0]    iterations_used;
    logic                          converged;
    logic [prk_pkg::STAT_W-1:0]    status;

    modport source (output valid, score, iterations_used, converged, status, input ready);
    modport sink   (input valid, score, iterations_used, converged, status, output ready);
endinterface

// ----- hdl/prk_div.sv -----
// unsigned restoring divider, one quotient bit per cycle
// depends on prk_pkg for operand widths
module prk_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [prk_pkg::DIV_W-1:0]   i_dividend,
    input  logic [prk_pkg::DVS_W-1:0]   i_divisor,
    output logic                        o_busy,
    output logic [prk_pkg::DIV_W-1:0]   o_quot
);
    import prk_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_quot;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W:0]    w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_quot[DIV_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(DIV_W);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_W-2:0], w_fit};
            r_rem  <= w_fit ? DVS_W'(w_trial - {1'b0, r_dvs}) : w_trial[DVS_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

// ----- hdl/prk_datapath.sv -----
// datapath: configuration registers, edge, degree, score and accumulator memories,
// multiplier, shared divider and run counters; depends on prk_pkg and prk_div
module prk_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [prk_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [prk_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [prk_pkg::REQ_W-1:0]       i_req_type,
    input  logic [prk_pkg::NODE_W-1:0]      i_src_node,
    input  logic [prk_pkg::NODE_W-1:0]      i_dst_node,
    input  prk_pkg::t_cmd                   i_cmd,
    output prk_pkg::t_dp_status             o_st,
    output logic [prk_pkg::SCORE_W-1:0]     o_score,
    output logic [prk_pkg::ITER_W-1:0]      o_iterations_used,
    output logic                            o_converged,
    output logic [prk_pkg::STAT_W-1:0]      o_status
);
    import prk_pkg::*;

    logic [NCFG_W-1:0]  r_cfg_nodes;
    logic [ALPHA_W-1:0] r_alpha;
    logic [ITER_W-1:0]  r_maxit;
    logic [TOL_W-1:0]   r_tol;

    logic [2*NODE_W-1:0] m_edge  [EDGES_MAX];
    logic [DEG_W-1:0]    m_deg   [NODES_MAX];
    logic [SCORE_W-1:0]  m_score [NODES_MAX];
    logic [ACC_W-1:0]    m_acc   [NODES_MAX];

    logic [2*NODE_W-1:0] r_edge_rd;
    logic [DEG_W-1:0]    r_deg_rd;
    logic [SCORE_W-1:0]  r_score_rd;
    logic [ACC_W-1:0]    r_acc_rd;

    logic [NODE_W-1:0]  r_src;
    logic [NODE_W-1:0]  r_dst;
    logic [ETOT_W-1:0]  r_edge_total;
    logic [IDX_W-1:0]   r_idx;
    logic [PROD_W-1:0]  r_prod;
    logic               r_deg0;
    logic               r_edge_ok;
    logic [DSUM_W-1:0]  r_dsum;
    logic [DSUM_W-1:0]  r_dang;
    logic [SCORE_W-1:0] r_init;
    logic [SCORE_W-1:0] r_tele;
    logic [ERR_W-1:0]   r_err;
    logic [ITER_W-1:0]  r_iter;
    logic               r_conv;
    logic [SCORE_W-1:0] r_rscore;
    t_status            r_status;

    logic [CNT_W-1:0]   w_n;
    logic [OMA_W-1:0]   w_oma;
    logic [SHARE_W-1:0] w_share;
    logic [NODE_W-1:0]  w_naddr;
    logic [NODE_W-1:0]  w_e_src;
    logic [NODE_W-1:0]  w_e_dst;
    logic [LIM_W-1:0]   w_limit;
    logic [NV_W-1:0]    w_sum;
    logic [SCORE_W-1:0] w_nv;
    logic [SCORE_W-1:0] w_diff;
    logic               w_add_range;
    logic               w_add_ok;
    logic               w_div_start;
    logic [DIV_W-1:0]   w_dividend;
    logic [DVS_W-1:0]   w_divisor;
    logic               w_div_busy;
    logic [DIV_W-1:0]   w_quot;
    t_dp_op             w_op;

    assign w_op = i_cmd.op;

    // effective node count clamped to one through the store size
    always_comb begin
        if (r_cfg_nodes == '0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_cfg_nodes) > NODES_MAX) begin
            w_n = CNT_W'(NODES_MAX);
        end else begin
            w_n = CNT_W'(r_cfg_nodes);
        end
    end

    assign w_oma   = {1'b1, {ALPHA_W{1'b0}}} - {1'b0, r_alpha};
    assign w_share = r_prod[PROD_W-1:ALPHA_W];
    assign w_naddr = r_idx[NODE_W-1:0];
    assign w_e_src = r_edge_rd[2*NODE_W-1:NODE_W];
    assign w_e_dst = r_edge_rd[NODE_W-1:0];
    assign w_limit = LIM_W'(w_n) * LIM_W'(r_tol);

    assign w_sum  = NV_W'(r_acc_rd) + NV_W'(r_dang) + NV_W'(r_tele);
    assign w_nv   = (|w_sum[NV_W-1:SCORE_W]) ? {SCORE_W{1'b1}} : w_sum[SCORE_W-1:0];
    assign w_diff = (w_nv > r_score_rd) ? (w_nv - r_score_rd) : (r_score_rd - w_nv);

    assign w_add_range = (CNT_W'(r_src) >= w_n) || (CNT_W'(r_dst) >= w_n);
    assign w_add_ok    = !w_add_range && (32'(r_edge_total) < EDGES_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_nodes <= NODES_RST;
            r_alpha     <= ALPHA_RST;
            r_maxit     <= MAXIT_RST;
            r_tol       <= TOL_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NODES: r_cfg_nodes <= i_cfg_data[NCFG_W-1:0];
                CFG_ALPHA: r_alpha     <= i_cfg_data[ALPHA_W-1:0];
                CFG_MAXIT: r_maxit     <= i_cfg_data[ITER_W-1:0];
                CFG_TOL:   r_tol       <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // divider operand selection
    always_comb begin
        w_div_start = 1'b1;
        w_dividend  = '0;
        w_divisor   = DVS_W'(w_n);
        case (w_op)
            DP_DIV_INIT: w_dividend = DIV_W'({1'b1, {(SCORE_W-1){1'b0}}});
            DP_DIV_TELE: w_dividend = DIV_W'({r_alpha, {(ALPHA_W-1){1'b0}}});
            DP_DIV_DANG: w_dividend = DIV_W'(r_dsum);
            DP_DIV_EDGE: begin
                w_dividend = DIV_W'(w_share);
                w_divisor  = DVS_W'(r_deg_rd);
            end
            default: w_div_start = 1'b0;
        endcase
    end

    prk_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    // edge store
    always_ff @(posedge i_clk) begin
        if (w_op == DP_ADD_WR && w_add_ok) begin
            m_edge[r_edge_total[EDGE_AW-1:0]] <= {r_src, r_dst};
        end
        if (w_op == DP_E_RD) begin
            r_edge_rd <= m_edge[r_idx[EDGE_AW-1:0]];
        end
    end

    // out-degree store
    always_ff @(posedge i_clk) begin
        if (w_op == DP_SWEEP) begin
            m_deg[w_naddr] <= '0;
        end else if (w_op == DP_ADD_WR && w_add_ok) begin
            m_deg[r_src] <= r_deg_rd + 1'b1;
        end
        case (w_op)
            DP_ADD_RD:  r_deg_rd <= m_deg[r_src];
            DP_DANG_RD: r_deg_rd <= m_deg[w_naddr];
            DP_E_RD2:   r_deg_rd <= m_deg[w_e_src];
            default: ;
        endcase
    end

    // score store
    always_ff @(posedge i_clk) begin
        case (w_op)
            DP_SWEEP:  m_score[w_naddr] <= '0;
            DP_FILL:   m_score[w_naddr] <= (r_idx < IDX_W'(w_n)) ? r_init : '0;
            DP_UPD_WR: m_score[w_naddr] <= w_nv;
            default: ;
        endcase
        case (w_op)
            DP_RD_RD:   r_score_rd <= m_score[r_src];
            DP_DANG_RD: r_score_rd <= m_score[w_naddr];
            DP_E_RD2:   r_score_rd <= m_score[w_e_src];
            DP_UPD_RD:  r_score_rd <= m_score[w_naddr];
            default: ;
        endcase
    end

    // per-node accumulator of edge shares
    always_ff @(posedge i_clk) begin
        case (w_op)
            DP_DANG_RD: m_acc[w_naddr] <= '0;
            DP_E_ACC:   m_acc[w_e_dst] <= r_acc_rd + ACC_W'(w_quot);
            default: ;
        endcase
        case (w_op)
            DP_E_RD2:  r_acc_rd <= m_acc[w_e_dst];
            DP_UPD_RD: r_acc_rd <= m_acc[w_naddr];
            default: ;
        endcase
    end

    // control counters and run results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_total <= '0;
            r_idx        <= '0;
            r_iter       <= '0;
            r_conv       <= 1'b0;
        end else begin
            case (w_op)
                DP_SWEEP, DP_FILL, DP_DANG_ADD, DP_E_SKIP, DP_E_ACC, DP_UPD_WR:
                    r_idx <= r_idx + 1'b1;
                DP_CLEAR: begin
                    r_edge_total <= '0;
                    r_idx        <= '0;
                end
                DP_ADD_WR: begin
                    if (w_add_ok) begin
                        r_edge_total <= r_edge_total + 1'b1;
                    end
                end
                DP_CAP_TELE: begin
                    r_iter <= '0;
                    r_conv <= 1'b0;
                    r_idx  <= '0;
                end
                DP_ITER_START, DP_CAP_DANG, DP_IDX_CLR: r_idx <= '0;
                DP_ITER_END: begin
                    r_iter <= r_iter + 1'b1;
                    r_conv <= o_st.err_below;
                end
                default: ;
            endcase
        end
    end

    // request payload, arithmetic registers and the response fields
    always_ff @(posedge i_clk) begin
        case (w_op)
            DP_LATCH: begin
                r_src    <= i_src_node;
                r_dst    <= i_dst_node;
                r_status <= ST_OK;
                r_rscore <= '0;
            end
            DP_ADD_WR: begin
                if (w_add_range) begin
                    r_status <= ST_RANGE;
                end else if (!w_add_ok) begin
                    r_status <= ST_FULL;
                end
            end
            DP_RD_CAP: begin
                if (CNT_W'(r_src) >= w_n) begin
                    r_status <= ST_RANGE;
                end else begin
                    r_rscore <= r_score_rd;
                end
            end
            DP_CAP_INIT: r_init <= w_quot[SCORE_W-1:0];
            DP_CAP_TELE: r_tele <= w_quot[SCORE_W-1:0];
            DP_ITER_START: begin
                r_dsum <= '0;
                r_err  <= '0;
            end
            DP_DANG_MUL: begin
                r_prod <= PROD_W'(w_oma) * PROD_W'(r_score_rd);
                r_deg0 <= (r_deg_rd == '0);
            end
            DP_DANG_ADD: begin
                if (r_deg0) begin
                    r_dsum <= r_dsum + DSUM_W'(w_share);
                end
            end
            DP_CAP_DANG: r_dang <= w_quot[DSUM_W-1:0];
            DP_E_MUL: begin
                r_prod    <= PROD_W'(w_oma) * PROD_W'(r_score_rd);
                // stale sources and targets at or above the node count are skipped
                r_edge_ok <= (CNT_W'(w_e_src) < w_n) && (CNT_W'(w_e_dst) < w_n)
                             && (r_deg_rd != '0);
            end
            DP_UPD_WR: r_err <= r_err + ERR_W'(w_diff);
            default: ;
        endcase
    end

    always_comb begin
        o_st.req            = t_req'(i_req_type);
        o_st.div_busy       = w_div_busy;
        o_st.idx_sweep_last = (r_idx == IDX_W'(NODES_MAX - 1));
        o_st.idx_n_last     = (r_idx == IDX_W'(w_n) - 1'b1);
        o_st.idx_edge_last  = (r_idx == IDX_W'(r_edge_total) - 1'b1);
        o_st.edges_empty    = (r_edge_total == '0);
        o_st.edge_ok        = r_edge_ok;
        o_st.max_zero       = (r_maxit == '0);
        o_st.err_below      = (r_err < ERR_W'(w_limit));
        o_st.iter_last      = (ITER_W'(r_iter + 1'b1) == r_maxit);
    end

    assign o_score           = r_rscore;
    assign o_iterations_used = r_iter;
    assign o_converged       = r_conv;
    assign o_status          = r_status;

    a_edge_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_edge_total) <= EDGES_MAX)
        else $error("edge total beyond edge store size");

    a_div_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> w_div_busy)
        else $error("divider did not start");

    a_acc_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == DP_E_ACC) |-> !w_div_busy)
        else $error("edge share used before quotient ready");

    a_upd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == DP_UPD_WR) |-> (r_idx < IDX_W'(w_n)))
        else $error("score update beyond node count");

endmodule

// ----- hdl/prk_ctrl.sv -----
// controller state machine: sequences requests, sweeps and power iterations
// depends on prk_pkg; drives the datapath by command and reads its status
module prk_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    input  prk_pkg::t_dp_status   i_st,
    output prk_pkg::t_cmd         o_cmd
);
    import prk_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = DP_NOP;
        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;
        case (r_state)
            S_RST_SWEEP: begin
                o_cmd.op = DP_SWEEP;
                if (i_st.idx_sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.op = DP_LATCH;
                    case (i_st.req)
                        REQ_ADD:  n_state = S_ADD_RD;
                        REQ_RUN:  n_state = S_INIT_DIV;
                        REQ_READ: n_state = S_RD_RD;
                        default:  n_state = S_CLR;
                    endcase
                end
            end
            S_ADD_RD: begin
                o_cmd.op = DP_ADD_RD;
                n_state  = S_ADD_WR;
            end
            S_ADD_WR: begin
                o_cmd.op = DP_ADD_WR;
                n_state  = S_RESP;
            end
            S_RD_RD: begin
                o_cmd.op = DP_RD_RD;
                n_state  = S_RD_CAP;
            end
            S_RD_CAP: begin
                o_cmd.op = DP_RD_CAP;
                n_state  = S_RESP;
            end
            S_CLR: begin
                o_cmd.op = DP_CLEAR;
                n_state  = S_CLR_SWEEP;
            end
            S_CLR_SWEEP: begin
                o_cmd.op = DP_SWEEP;
                if (i_st.idx_sweep_last) n_state = S_RESP;
            end
            S_INIT_DIV: begin
                o_cmd.op = DP_DIV_INIT;
                n_state  = S_INIT_WAIT;
            end
            S_INIT_WAIT: begin
                if (!i_st.div_busy) n_state = S_INIT_CAP;
            end
            S_INIT_CAP: begin
                o_cmd.op = DP_CAP_INIT;
                n_state  = S_TELE_DIV;
            end
            S_TELE_DIV: begin
                o_cmd.op = DP_DIV_TELE;
                n_state  = S_TELE_WAIT;
            end
            S_TELE_WAIT: begin
                if (!i_st.div_busy) n_state = S_TELE_CAP;
            end
            S_TELE_CAP: begin
                o_cmd.op = DP_CAP_TELE;
                n_state  = S_FILL;
            end
            S_FILL: begin
                o_cmd.op = DP_FILL;
                if (i_st.idx_sweep_last) n_state = i_st.max_zero ? S_RESP : S_ITER;
            end
            S_ITER: begin
                o_cmd.op = DP_ITER_START;
                n_state  = S_DANG_RD;
            end
            S_DANG_RD: begin
                o_cmd.op = DP_DANG_RD;
                n_state  = S_DANG_MUL;
            end
            S_DANG_MUL: begin
                o_cmd.op = DP_DANG_MUL;
                n_state  = S_DANG_ADD;
            end
            S_DANG_ADD: begin
                o_cmd.op = DP_DANG_ADD;
                n_state  = i_st.idx_n_last ? S_DANG_DIV : S_DANG_RD;
            end
            S_DANG_DIV: begin
                o_cmd.op = DP_DIV_DANG;
                n_state  = S_DANG_WAIT;
            end
            S_DANG_WAIT: begin
                if (!i_st.div_busy) n_state = S_DANG_CAP;
            end
            S_DANG_CAP: begin
                o_cmd.op = DP_CAP_DANG;
                n_state  = i_st.edges_empty ? S_UPD_START : S_E_RD;
            end
            S_E_RD: begin
                o_cmd.op = DP_E_RD;
                n_state  = S_E_RD2;
            end
            S_E_RD2: begin
                o_cmd.op = DP_E_RD2;
                n_state  = S_E_MUL;
            end
            S_E_MUL: begin
                o_cmd.op = DP_E_MUL;
                n_state  = S_E_DIV;
            end
            S_E_DIV: begin
                if (i_st.edge_ok) begin
                    o_cmd.op = DP_DIV_EDGE;
                    n_state  = S_E_WAIT;
                end else begin
                    o_cmd.op = DP_E_SKIP;
                    n_state  = i_st.idx_edge_last ? S_UPD_START : S_E_RD;
                end
            end
            S_E_WAIT: begin
                if (!i_st.div_busy) n_state = S_E_ACC;
            end
            S_E_ACC: begin
                o_cmd.op = DP_E_ACC;
                n_state  = i_st.idx_edge_last ? S_UPD_START : S_E_RD;
            end
            S_UPD_START: begin
                o_cmd.op = DP_IDX_CLR;
                n_state  = S_UPD_RD;
            end
            S_UPD_RD: begin
                o_cmd.op = DP_UPD_RD;
                n_state  = S_UPD_WR;
            end
            S_UPD_WR: begin
                o_cmd.op = DP_UPD_WR;
                n_state  = i_st.idx_n_last ? S_ITER_END : S_UPD_RD;
            end
            S_ITER_END: begin
                o_cmd.op = DP_ITER_END;
                n_state  = (i_st.err_below || i_st.iter_last) ? S_RESP : S_ITER;
            end
            S_RESP: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- hdl/pagerank_power_iteration.sv -----
// PageRank power iteration engine, one request at a time, one response beat per request.
// After reset the block clears all 1024 entries of its degree and score stores before it
// takes a request beat; a clear request runs the same sweep. An add-edge beat reads a degree
// and then writes the edge and degree stores; a read beat reads and then captures a score.
// A run divides for the initial score and the teleport share, fills all 1024 score entries,
// then per iteration sums the scaled score of each dangling node, divides that sum,
// reads and scales each stored edge, divides and accumulates each edge that passes a share,
// and updates each score; the shared bit-serial divider and single-port stores serialize this.
// depends on prk_pkg, prk_ifs, prk_div, prk_datapath and prk_ctrl
module pagerank_power_iteration (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [prk_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [prk_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    prk_req_if.sink                         i_req,
    prk_rsp_if.source                       o_rsp
);
    import prk_pkg::*;

    t_cmd       w_cmd;
    t_dp_status w_st;

    prk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_st        (w_st),
        .o_cmd       (w_cmd)
    );

    prk_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_req.req_type),
        .i_src_node        (i_req.src_node),
        .i_dst_node        (i_req.dst_node),
        .i_cmd             (w_cmd),
        .o_st              (w_st),
        .o_score           (o_rsp.score),
        .o_iterations_used (o_rsp.iterations_used),
        .o_converged       (o_rsp.converged),
        .o_status          (o_rsp.status)
    );

endmodule

// ----- tb/prk_checker.sv -----
// response checker for the pagerank block: predicts each response beat and compares
// depends on prk_pkg and the channel interfaces in prk_ifs
`timescale 1ns / 1ps
module prk_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [prk_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [prk_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    prk_req_if                              i_req,
    prk_rsp_if                              i_rsp,
    output int                              o_fail_count,
    output int                              o_pending
);
    import prk_pkg::*;

    typedef struct {
        logic [SCORE_W-1:0] score;
        logic [ITER_W-1:0]  iters;
        logic               conv;
        t_status            status;
    } t_rank_rsp;

    t_rank_rsp expected_rsp_q[$];

    logic [NCFG_W-1:0]  cfg_nodes = NODES_RST;
    logic [ALPHA_W-1:0] cfg_alpha = ALPHA_RST;
    logic [ITER_W-1:0]  cfg_maxit = MAXIT_RST;
    logic [TOL_W-1:0]   cfg_tol   = TOL_RST;

    logic [NODE_W-1:0]  edge_src [EDGES_MAX];
    logic [NODE_W-1:0]  edge_dst [EDGES_MAX];
    int unsigned        edge_cnt;
    int unsigned        degree [NODES_MAX];
    logic [SCORE_W-1:0] rank [NODES_MAX];
    logic [ITER_W-1:0]  last_iters;
    logic               last_conv;

    int fails;
    assign o_fail_count = fails;
    assign o_pending    = expected_rsp_q.size();

    initial begin
        fails      = 0;
        edge_cnt   = 0;
        last_iters = '0;
        last_conv  = 1'b0;
        for (int v = 0; v < NODES_MAX; v++) begin
            degree[v] = 0;
            rank[v]   = '0;
        end
    end

    function automatic int unsigned live_nodes();
        int unsigned n;
        n = cfg_nodes;
        if (n < 1) n = 1;
        if (n > NODES_MAX) n = NODES_MAX;
        return n;
    endfunction

    function automatic void power_iterate();
        int unsigned      n;
        bit [63:0]        oma, tele, limit, dsum, dshare, err, nv64;
        bit [63:0]        acc [NODES_MAX];
        logic [SCORE_W-1:0] nxt [NODES_MAX];
        int unsigned      s, d;
        n     = live_nodes();
        oma   = 64'd65536 - cfg_alpha;
        tele  = (64'(cfg_alpha) << 15) / n;
        limit = 64'(n) * cfg_tol;
        for (int v = 0; v < NODES_MAX; v++)
            rank[v] = (v < n) ? SCORE_W'((64'd1 << 31) / n) : '0;
        last_iters = '0;
        last_conv  = 1'b0;
        for (int it = 0; it < cfg_maxit; it++) begin
            for (int v = 0; v < NODES_MAX; v++) acc[v] = '0;
            for (int e = 0; e < edge_cnt; e++) begin
                s = edge_src[e];
                d = edge_dst[e];
                if (s < n && d < n && degree[s] != 0)
                    acc[d] += ((oma * rank[s]) >> 16) / degree[s];
            end
            dsum = '0;
            for (int v = 0; v < n; v++)
                if (degree[v] == 0) dsum += (oma * rank[v]) >> 16;
            dshare = dsum / n;
            err = '0;
            for (int v = 0; v < n; v++) begin
                nv64   = acc[v] + dshare + tele;
                nxt[v] = (nv64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nv64[31:0];
                err   += (nxt[v] > rank[v]) ? 64'(nxt[v] - rank[v]) : 64'(rank[v] - nxt[v]);
            end
            for (int v = 0; v < n; v++) rank[v] = nxt[v];
            last_iters = ITER_W'(it + 1);
            if (err < limit) begin
                last_conv = 1'b1;
                break;
            end
        end
    endfunction

    function automatic t_rank_rsp predict_rank_rsp(t_req rq, logic [NODE_W-1:0] s,
                                                   logic [NODE_W-1:0] d);
        t_rank_rsp   r;
        int unsigned n;
        n = live_nodes();
        r.score  = '0;
        r.status = ST_OK;
        case (rq)
            REQ_ADD: begin
                if (s >= n || d >= n) r.status = ST_RANGE;
                else if (edge_cnt >= EDGES_MAX) r.status = ST_FULL;
                else begin
                    edge_src[edge_cnt] = s;
                    edge_dst[edge_cnt] = d;
                    edge_cnt++;
                    degree[s]++;
                end
            end
            REQ_RUN: power_iterate();
            REQ_READ: begin
                if (s >= n) r.status = ST_RANGE;
                else r.score = rank[s];
            end
            default: begin
                edge_cnt = 0;
                for (int v = 0; v < NODES_MAX; v++) begin
                    degree[v] = 0;
                    rank[v]   = '0;
                end
            end
        endcase
        r.iters = last_iters;
        r.conv  = last_conv;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] response %s: got %0d, expected %0d", $time, what, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NODES: cfg_nodes <= i_cfg_data[NCFG_W-1:0];
                CFG_ALPHA: cfg_alpha <= i_cfg_data[ALPHA_W-1:0];
                CFG_MAXIT: cfg_maxit <= i_cfg_data[ITER_W-1:0];
                CFG_TOL:   cfg_tol   <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_rank_rsp want;
        if (i_rst_n && i_req.valid && i_req.ready)
            expected_rsp_q.push_back(predict_rank_rsp(t_req'(i_req.req_type),
                                                      i_req.src_node, i_req.dst_node));
        if (i_rst_n && i_rsp.valid && i_rsp.ready) begin
            if (expected_rsp_q.size() == 0) begin
                report_mismatch("beat with nothing pending", 1, 0);
            end else begin
                want = expected_rsp_q.pop_front();
                if (i_rsp.score !== want.score)
                    report_mismatch("score", i_rsp.score, want.score);
                if (i_rsp.iterations_used !== want.iters)
                    report_mismatch("iterations_used", i_rsp.iterations_used, want.iters);
                if (i_rsp.converged !== want.conv)
                    report_mismatch("converged", i_rsp.converged, want.conv);
                if (i_rsp.status !== want.status)
                    report_mismatch("status", i_rsp.status, want.status);
            end
        end
    end
endmodule

// ----- tb/pagerank_power_iteration_tb.sv -----
// top of the pagerank block testbench: clock, reset, request stimulus and verdict
// depends on prk_pkg, prk_ifs, the block and prk_checker
`timescale 1ns / 1ps
module pagerank_power_iteration_tb;
    import prk_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    prk_req_if req_ch ();
    prk_rsp_if rsp_ch ();

    pagerank_power_iteration i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    prk_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    bit          no_idle;
    int          beats_sent;
    int          runs_sent;
    int unsigned nodes_now;
    int unsigned maxit_now;
    int unsigned edges_now;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // response side stalls
    initial begin
        int k;
        rsp_ch.ready = 1'b0;
        forever begin
            k = no_idle ? 0 : $urandom_range(0, 18);
            if (k > 0) begin
                @(negedge i_clk) rsp_ch.ready = 1'b0;
                repeat (k - 1) @(negedge i_clk);
            end
            @(negedge i_clk) rsp_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
        end
    end

    task automatic send_beat(t_req rq, logic [NODE_W-1:0] s, logic [NODE_W-1:0] d);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            @(negedge i_clk) req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid    = 1'b1;
        req_ch.req_type = rq;
        req_ch.src_node = s;
        req_ch.dst_node = d;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        beats_sent++;
        if (rq == REQ_RUN) runs_sent++;
        if (rq == REQ_CLEAR) edges_now = 0;
        if (rq == REQ_ADD && s < nodes_now && d < nodes_now) edges_now++;
    endtask

    // wait until every response is back, then let the block settle
    task automatic drain();
        @(negedge i_clk) req_ch.valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_reg(t_cfg_idx idx, int unsigned value);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = CFG_DATA_W'(value);
        @(negedge i_clk) cfg_we = 1'b0;
        if (idx == CFG_NODES)
            nodes_now = (value[10:0] == 0) ? 1 : (value[10:0] > NODES_MAX ? NODES_MAX
                                                                          : value[10:0]);
        if (idx == CFG_MAXIT) maxit_now = value[7:0];
    endtask

    task automatic set_all(int unsigned n, int unsigned a, int unsigned m, int unsigned t);
        drain();
        set_reg(CFG_NODES, n);
        set_reg(CFG_ALPHA, a);
        set_reg(CFG_MAXIT, m);
        set_reg(CFG_TOL, t);
    endtask

    function automatic logic [NODE_W-1:0] pick_node();
        return NODE_W'($urandom_range(0, nodes_now - 1));
    endfunction

    task automatic noise_beat();
        t_req rq;
        rq = t_req'($urandom_range(0, 3));
        // keep runs cheap: small graphs only
        if (rq == REQ_RUN && (nodes_now > 64 || edges_now > 16)) rq = REQ_READ;
        send_beat(rq, NODE_W'($urandom), NODE_W'($urandom));
    endtask

    initial begin
        int k;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_ADD;
        req_ch.src_node = '0;
        req_ch.dst_node = '0;
        cfg_we     = 1'b0;
        cfg_idx    = CFG_NODES;
        cfg_data   = '0;
        no_idle    = 1'b0;
        beats_sent = 0;
        runs_sent  = 0;
        nodes_now  = NODES_MAX;
        maxit_now  = 100;
        edges_now  = 0;
        i_rst_n    = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // directed: defaults, extreme indices, self loop
        send_beat(REQ_READ, 10'd0, 10'd0);
        send_beat(REQ_READ, 10'd1023, 10'd1023);
        send_beat(REQ_ADD, 10'd0, 10'd1023);
        send_beat(REQ_ADD, 10'd1023, 10'd0);
        send_beat(REQ_ADD, 10'd5, 10'd5);
        send_beat(REQ_CLEAR, 10'd0, 10'd0);
        // zero iteration limit
        set_all(4, 0, 0, 0);
        send_beat(REQ_RUN, 10'd0, 10'd0);
        send_beat(REQ_READ, 10'd3, 10'd0);
        // full restart, no tolerance: runs to the limit, node 2 dangling
        set_all(3, 65535, 255, 0);
        send_beat(REQ_ADD, 10'd0, 10'd1);
        send_beat(REQ_ADD, 10'd1, 10'd2);
        send_beat(REQ_RUN, 10'd0, 10'd0);
        for (int v = 0; v < 3; v++) send_beat(REQ_READ, NODE_W'(v), 10'd0);
        send_beat(REQ_READ, 10'd3, 10'd0);
        send_beat(REQ_ADD, 10'd3, 10'd0);
        send_beat(REQ_ADD, 10'd0, 10'd3);
        // stale edge target after lowering the count, then a node beyond it
        set_all(2, 9830, 5, 65535);
        send_beat(REQ_RUN, 10'd0, 10'd0);
        set_all(3, 9830, 5, 65535);
        send_beat(REQ_READ, 10'd2, 10'd0);
        // widest graph, count clamped from above
        set_all(2047, 9830, 1, 65535);
        send_beat(REQ_CLEAR, 10'd0, 10'd0);
        send_beat(REQ_ADD, 10'd1023, 10'd1023);
        send_beat(REQ_RUN, 10'd0, 10'd0);
        send_beat(REQ_READ, 10'd1023, 10'd0);

        // random phases, mostly clear / edges / run / reads
        while (beats_sent < 1500) begin
            no_idle = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0:       k = 1;
                1:       k = 0;
                2:       k = $urandom_range(17, 64);
                default: k = $urandom_range(2, 16);
            endcase
            set_all(k, ($urandom_range(0, 5) == 0) ? 65535 * $urandom_range(0, 1)
                                                    : $urandom_range(0, 65535),
                    $urandom_range(1, 12),
                    ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 65535));
            if ($urandom_range(0, 4) != 0) begin
                send_beat(REQ_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
                repeat ($urandom_range(0, 12)) begin
                    if ($urandom_range(0, 7) == 0) noise_beat();
                    else send_beat(REQ_ADD, pick_node(), pick_node());
                end
                if ($urandom_range(0, 5) == 0 && nodes_now > 1) begin
                    drain();
                    set_reg(CFG_NODES, $urandom_range(1, nodes_now - 1));
                end
                if (edges_now <= 16) send_beat(REQ_RUN, NODE_W'($urandom), NODE_W'($urandom));
                if ($urandom_range(0, 3) == 0) begin
                    drain();
                    set_reg(CFG_NODES, $urandom_range(nodes_now, 64));
                end
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 5) == 0) noise_beat();
                    else send_beat(REQ_READ, pick_node(), NODE_W'($urandom));
                end
            end else begin
                repeat ($urandom_range(5, 20)) noise_beat();
            end
        end

        drain();

        $display("covered %0d request beats, %0d of them runs, with random stalls",
                 beats_sent, runs_sent);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
